@@ design/see_pkg.sv @@
// Shared types, constants and codes of the stack expression evaluator.
`timescale 1ns / 1ps
package see_pkg;
    localparam int DataWidth = 32;
    localparam int StackDepthDefault = 64;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_POW  = 4'd4;
    localparam logic [3:0] OP_NEG  = 4'd5;
    localparam logic [3:0] OP_PSHI = 4'd6;
    localparam logic [3:0] OP_PSHX = 4'd7;
    localparam logic [3:0] OP_PSHY = 4'd8;
    localparam logic [3:0] OP_PSHZ = 4'd9;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_OPCODE  = 3'd1;
    localparam logic [2:0] ERR_UNDER   = 3'd2;
    localparam logic [2:0] ERR_OVER    = 3'd3;
    localparam logic [2:0] ERR_DIVZERO = 3'd4;
    localparam logic [2:0] ERR_ZEROPOW = 3'd5;

    // datapath commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1; // fetch top two entries
    localparam logic [2:0] CMD_EXEC  = 3'd2; // start the operation on fetched operands
    localparam logic [2:0] CMD_STEP  = 3'd3; // one iteration of div or pow
    localparam logic [2:0] CMD_WRITE = 3'd4; // write back and retire the beat

    typedef struct packed {
        logic [2:0] cmd;
    } see_ctrl_t;

    typedef struct packed {
        logic wb_hold;   // last beat must wait for the result slot
        logic busy_done; // iterative unit finished
        logic iterative; // fetched op needs the iterative unit
    } see_stat_t;
endpackage

@@ design/see_if.sv @@
// Valid/ready channel interfaces for instructions and results.
`timescale 1ns / 1ps
interface see_instr_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic signed [31:0] immediate;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] z_value;
    logic        last_instr;
    modport source (output valid, opcode, immediate, x_value, y_value, z_value, last_instr,
                    input ready);
    modport sink (input valid, opcode, immediate, x_value, y_value, z_value, last_instr,
                  output ready);
endinterface

interface see_result_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic [2:0]  error_code;
    modport source (output valid, result_value, error_code, input ready);
    modport sink (input valid, result_value, error_code, output ready);
endinterface

@@ design/see_ctrl.sv @@
// Controller state machine: sequences fetch, execute, iterate and write back.
`timescale 1ns / 1ps
module see_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  see_pkg::see_stat_t   stat,
    output see_pkg::see_ctrl_t   ctrl
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_ITER = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl.cmd = see_pkg::CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctrl.cmd = see_pkg::CMD_READ;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctrl.cmd = see_pkg::CMD_EXEC;
                state_next = stat.iterative ? S_ITER : S_WB;
            end
            S_ITER:
            begin
                ctrl.cmd = see_pkg::CMD_STEP;
                if (stat.busy_done)
                    state_next = S_WB;
            end
            S_WB:
            begin
                // a last beat waits until the result slot can take it
                if (!stat.wb_hold)
                begin
                    ctrl.cmd = see_pkg::CMD_WRITE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_no_write_held: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmd == see_pkg::CMD_WRITE) |-> !stat.wb_hold)
        else $error("write back while result slot is full");
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmd == see_pkg::CMD_READ) |=> (ctrl.cmd == see_pkg::CMD_EXEC))
        else $error("fetch not followed by execute");
    a_wb_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmd == see_pkg::CMD_WRITE) |=> (state_reg == S_IDLE))
        else $error("write back did not return to idle");
`endif
endmodule

@@ design/see_dp.sv @@
// Datapath: operand stack memory, pointer, error, ALU and iterative div/pow unit.
`timescale 1ns / 1ps
module see_dp #(
    parameter int STACK_DEPTH = see_pkg::StackDepthDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  see_pkg::see_ctrl_t   ctrl,
    output see_pkg::see_stat_t   stat,
    input  logic [3:0]           opcode,
    input  logic [31:0]          immediate,
    input  logic [31:0]          x_value,
    input  logic [31:0]          y_value,
    input  logic [31:0]          z_value,
    input  logic                 last_instr,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [31:0]          result_value,
    output logic [2:0]           error_code
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [PW-1:0] DEPTH_P = PW'(STACK_DEPTH);
    localparam logic [PW-1:0] ONE_P = PW'(1);
    localparam logic [PW-1:0] TWO_P = PW'(2);

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rd_a_reg, rd_b_reg;
    logic [PW-1:0] sp_reg;
    logic [2:0]  err_reg;
    logic [3:0]  op_reg;
    logic [31:0] push_reg;
    logic        last_reg;
    logic [31:0] r_reg;
    logic [2:0]  new_err_reg;
    logic        do_pop_reg, do_push_reg, do_neg_reg;

    // iterative unit
    logic [31:0] it_acc_reg, it_base_reg, it_cnt_reg, it_rem_reg;
    logic        it_negq_reg, it_isdiv_reg;
    logic [5:0]  it_n_reg;

    logic [AW-1:0] addr_b, addr_a;
    assign addr_b = AW'(sp_reg - ONE_P);
    assign addr_a = AW'(sp_reg - TWO_P);

    logic [31:0] a, b, mag_a, mag_b;
    assign a = rd_a_reg;
    assign b = rd_b_reg;
    assign mag_a = a[31] ? (32'd0 - a) : a;
    assign mag_b = b[31] ? (32'd0 - b) : b;

    logic is_bin, is_push;
    assign is_bin = (op_reg == see_pkg::OP_ADD) || (op_reg == see_pkg::OP_SUB) ||
                    (op_reg == see_pkg::OP_MUL) || (op_reg == see_pkg::OP_DIV) ||
                    (op_reg == see_pkg::OP_POW);
    assign is_push = (op_reg == see_pkg::OP_PSHI) || (op_reg == see_pkg::OP_PSHX) ||
                     (op_reg == see_pkg::OP_PSHY) || (op_reg == see_pkg::OP_PSHZ);

    // execute-phase decision
    logic [2:0]  ex_err;
    logic        ex_iter;
    always_comb
    begin
        ex_err = see_pkg::ERR_OK;
        ex_iter = 1'b0;
        if (is_bin)
        begin
            if (sp_reg < TWO_P)
                ex_err = see_pkg::ERR_UNDER;
            else if (op_reg == see_pkg::OP_DIV)
            begin
                if (b == 32'd0)
                    ex_err = see_pkg::ERR_DIVZERO;
                else
                    ex_iter = 1'b1;
            end
            else if (op_reg == see_pkg::OP_POW)
            begin
                if (a == 32'd0 && b[31])
                    ex_err = see_pkg::ERR_ZEROPOW;
                else if (!b[31])
                    ex_iter = 1'b1;
            end
        end
        else if (op_reg == see_pkg::OP_NEG)
        begin
            if (sp_reg < ONE_P)
                ex_err = see_pkg::ERR_UNDER;
        end
        else if (is_push)
        begin
            if (sp_reg >= DEPTH_P)
                ex_err = see_pkg::ERR_OVER;
        end
        else
            ex_err = see_pkg::ERR_OPCODE;
        if (err_reg != see_pkg::ERR_OK)
        begin
            ex_err = see_pkg::ERR_OK;
            ex_iter = 1'b0;
        end
    end

    logic [31:0] ex_r;
    always_comb
    begin
        case (op_reg)
            see_pkg::OP_ADD: ex_r = a + b;
            see_pkg::OP_SUB: ex_r = a - b;
            see_pkg::OP_MUL: ex_r = a * b;
            see_pkg::OP_NEG: ex_r = 32'd0 - b;
            see_pkg::OP_POW:
            begin
                if (a == 32'd1)
                    ex_r = 32'd1;
                else if (a == 32'hFFFF_FFFF)
                    ex_r = b[0] ? 32'hFFFF_FFFF : 32'd1;
                else
                    ex_r = 32'd0;
            end
            default: ex_r = push_reg;
        endcase
    end

    assign stat.iterative = ex_iter;
    assign stat.busy_done = (it_n_reg == 6'd0);
    assign stat.wb_hold = last_reg && res_valid && !res_ready;

    // restoring divide step
    logic [32:0] trial;
    logic [31:0] rem_sh;
    assign rem_sh = {it_rem_reg[30:0], it_acc_reg[31]};
    assign trial = {1'b0, rem_sh} - {1'b0, it_base_reg};

    logic [31:0] final_r;
    assign final_r = it_isdiv_reg ? (it_negq_reg ? (32'd0 - it_acc_reg) : it_acc_reg)
                                  : it_acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == see_pkg::CMD_READ)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
        if (ctrl.cmd == see_pkg::CMD_WRITE && do_push_reg)
            mem[AW'(sp_reg)] <= r_reg;
        else if (ctrl.cmd == see_pkg::CMD_WRITE && do_pop_reg)
            mem[addr_a] <= r_reg;
        else if (ctrl.cmd == see_pkg::CMD_WRITE && do_neg_reg)
            mem[addr_b] <= r_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == see_pkg::CMD_READ)
        begin
            op_reg <= opcode;
            last_reg <= last_instr;
            case (opcode)
                see_pkg::OP_PSHX: push_reg <= x_value;
                see_pkg::OP_PSHY: push_reg <= y_value;
                see_pkg::OP_PSHZ: push_reg <= z_value;
                default:          push_reg <= immediate;
            endcase
        end
        if (ctrl.cmd == see_pkg::CMD_EXEC)
        begin
            new_err_reg <= ex_err;
            r_reg <= ex_r;
            do_pop_reg <= (err_reg == see_pkg::ERR_OK) && (ex_err == see_pkg::ERR_OK) && is_bin;
            do_push_reg <= (err_reg == see_pkg::ERR_OK) && (ex_err == see_pkg::ERR_OK)
                           && is_push;
            do_neg_reg <= (err_reg == see_pkg::ERR_OK) && (ex_err == see_pkg::ERR_OK)
                          && (op_reg == see_pkg::OP_NEG);
            it_isdiv_reg <= (op_reg == see_pkg::OP_DIV);
            it_negq_reg <= a[31] ^ b[31];
            it_n_reg <= 6'd32;
            if (op_reg == see_pkg::OP_DIV)
            begin
                it_acc_reg <= mag_a;
                it_base_reg <= mag_b;
                it_rem_reg <= 32'd0;
                it_cnt_reg <= 32'd0;
            end
            else
            begin
                it_acc_reg <= 32'd1;
                it_base_reg <= a;
                it_cnt_reg <= b;
                it_rem_reg <= 32'd0;
            end
        end
        else if (ctrl.cmd == see_pkg::CMD_STEP)
        begin
            if (it_n_reg != 6'd0)
            begin
                it_n_reg <= it_n_reg - 6'd1;
                if (it_isdiv_reg)
                begin
                    if (!trial[32])
                    begin
                        it_rem_reg <= trial[31:0];
                        it_acc_reg <= {it_acc_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        it_rem_reg <= rem_sh;
                        it_acc_reg <= {it_acc_reg[30:0], 1'b0};
                    end
                end
                else
                begin
                    // accumulate and square side by side, one exponent bit per cycle
                    if (it_cnt_reg[0])
                        it_acc_reg <= it_acc_reg * it_base_reg;
                    it_base_reg <= it_base_reg * it_base_reg;
                    it_cnt_reg <= {1'b0, it_cnt_reg[31:1]};
                end
            end
            else
                r_reg <= final_r;
        end
    end

    // pointer, error and result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            err_reg <= see_pkg::ERR_OK;
            res_valid <= 1'b0;
            result_value <= '0;
            error_code <= see_pkg::ERR_OK;
        end
        else
        begin
            if (res_valid && res_ready)
                res_valid <= 1'b0;
            if (ctrl.cmd == see_pkg::CMD_WRITE)
            begin
                if (last_reg)
                begin
                    res_valid <= 1'b1;
                    error_code <= (err_reg != see_pkg::ERR_OK) ? err_reg : new_err_reg;
                    if (do_push_reg)
                        result_value <= r_reg;
                    else if (do_pop_reg || do_neg_reg)
                        result_value <= r_reg;
                    else if (sp_reg != '0)
                        result_value <= (sp_reg == ONE_P) ? rd_b_reg : rd_b_reg;
                    else
                        result_value <= '0;
                    sp_reg <= '0;
                    err_reg <= see_pkg::ERR_OK;
                end
                else
                begin
                    if (err_reg == see_pkg::ERR_OK)
                        err_reg <= new_err_reg;
                    if (do_push_reg)
                        sp_reg <= sp_reg + ONE_P;
                    else if (do_pop_reg)
                        sp_reg <= sp_reg - ONE_P;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= DEPTH_P) else $error("stack pointer beyond depth");
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != see_pkg::ERR_OK && $past(ctrl.cmd) != see_pkg::CMD_WRITE)
        |-> $stable(sp_reg)) else $error("stack moved after error");
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg <= see_pkg::ERR_ZEROPOW) else $error("bad error code");
`endif
endmodule

@@ design/stack_expression_evaluator_unit.sv @@
// Top level of the stack expression evaluator.
`timescale 1ns / 1ps
// One instruction beat at a time runs on an operand stack of STACK_DEPTH 32-bit
// entries. Push, add, sub, mul and neg pass through accept with the stack
// fetch, execute and write back; div and pow that reach the shared iterative
// unit also step through it (32 quotient or exponent bits, then the final
// value). A beat with last_instr set yields one result beat with the top of
// stack and the first error of the program, then the stack is emptied. Input
// beats are taken while a result waits at the output; only the write back of a
// later last beat stalls until that result is taken.
module stack_expression_evaluator_unit #(
    parameter int STACK_DEPTH = see_pkg::StackDepthDefault
) (
    input  logic clk,
    input  logic rst_n,
    see_instr_if.sink    instr,
    see_result_if.source result
);
    see_pkg::see_ctrl_t ctrl;
    see_pkg::see_stat_t stat;

    see_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (instr.valid),
        .in_ready (instr.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    see_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .opcode       (instr.opcode),
        .immediate    (instr.immediate),
        .x_value      (instr.x_value),
        .y_value      (instr.y_value),
        .z_value      (instr.z_value),
        .last_instr   (instr.last_instr),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .result_value (result.result_value),
        .error_code   (result.error_code)
    );
endmodule
